// ===== src/crpm_pkg.sv =====
// crpm_pkg: shared types, constants and the identifier sequence table
// for the CAN register poll manager. No dependencies.
package crpm_pkg;

    localparam int unsigned IdW      = 11;
    localparam int unsigned WordW    = 16;
    localparam int unsigned LimitW   = 8;
    localparam int unsigned SeqW     = 3;
    localparam int unsigned NumRegs  = 9;
    localparam int unsigned SDataW   = 64;
    localparam int unsigned MDataW   = 160;

    localparam logic [IdW-1:0] ID_CONTROL  = 11'h600;
    localparam logic [IdW-1:0] ID_POWER    = 11'h601;
    localparam logic [IdW-1:0] ID_VOLTAGE  = 11'h602;
    localparam logic [IdW-1:0] ID_CURRENT  = 11'h603;
    localparam logic [IdW-1:0] ID_STATUS   = 11'h610;
    localparam logic [IdW-1:0] ID_MEASURE  = 11'h612;

    localparam logic [LimitW-1:0] LIMIT_RESET = 8'd5;
    localparam logic [LimitW-1:0] COUNT_MAX   = 8'd255;

    // item kinds on the input tuser
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // readback register slots
    localparam int unsigned RB_CONTROL  = 0;
    localparam int unsigned RB_POWER    = 1;
    localparam int unsigned RB_VOLTAGE  = 2;
    localparam int unsigned RB_CURRENT  = 3;
    localparam int unsigned RB_STATUS   = 4;
    localparam int unsigned RB_ERROR    = 5;
    localparam int unsigned RB_OPOWER   = 6;
    localparam int unsigned RB_OVOLTAGE = 7;
    localparam int unsigned RB_OCURRENT = 8;

    typedef logic [WordW-1:0] t_word;
    typedef t_word [NumRegs-1:0] t_regs;

    // one accepted item as seen by the sub-blocks
    typedef struct packed {
        logic           accept;
        logic           kind;
        logic [IdW-1:0] frame_id;
        logic           remote;
        t_word          word0;
        t_word          word1;
        t_word          word2;
    } t_item;

    // next identifier after the sequence moves to seq; steps 5 and 7 hold
    function automatic logic [IdW-1:0] seq_next_id(input logic [SeqW-1:0] seq,
                                                   input logic [IdW-1:0] cur);
        logic [IdW-1:0] id;
        unique case (seq)
            3'd0:    id = ID_CONTROL;
            3'd1:    id = ID_POWER;
            3'd2:    id = ID_VOLTAGE;
            3'd3:    id = ID_CURRENT;
            3'd4:    id = ID_STATUS;
            3'd6:    id = ID_MEASURE;
            default: id = cur;
        endcase
        return id;
    endfunction

endpackage

// ===== src/crpm_sequencer.sv =====
// crpm_sequencer: send/wait poll sequencer with timeout and answer matching.
// Depends on crpm_pkg. Request outputs are registered per accepted item.
module crpm_sequencer import crpm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_item              i_item,
    input  logic [LimitW-1:0]  i_timeout_limit,
    output logic               o_req_valid,
    output logic [IdW-1:0]     o_req_id
);

    logic              r_wait_phase, n_wait_phase;
    logic [IdW-1:0]    r_current_id, n_current_id;
    logic [SeqW-1:0]   r_seq, n_seq;
    logic [LimitW-1:0] r_wait_count, n_wait_count;
    logic [IdW-1:0]    r_asked_id, n_asked_id;
    logic              r_answer_seen, n_answer_seen;
    logic              r_req_valid, n_req_valid;
    logic [IdW-1:0]    r_req_id, n_req_id;

    always_comb begin
        n_wait_phase  = r_wait_phase;
        n_current_id  = r_current_id;
        n_seq         = r_seq;
        n_wait_count  = r_wait_count;
        n_asked_id    = r_asked_id;
        n_answer_seen = r_answer_seen;
        n_req_valid   = 1'b0;
        n_req_id      = '0;
        if (i_item.kind == KIND_TICK) begin
            if (!r_wait_phase) begin
                n_wait_count = '0;
                n_wait_phase = 1'b1;
                n_asked_id   = r_current_id;
                n_req_valid  = 1'b1;
                n_req_id     = r_current_id;
            end else begin
                if (r_answer_seen) begin
                    n_answer_seen = 1'b0;
                    n_seq         = r_seq + 1'b1;
                    n_current_id  = seq_next_id(n_seq, r_current_id);
                    n_wait_phase  = 1'b0;
                end else if (r_wait_count != COUNT_MAX) begin
                    n_wait_count = r_wait_count + 1'b1;
                end
                if (n_wait_count > i_timeout_limit) begin
                    n_wait_phase = 1'b0;
                end
            end
        end else begin
            // any frame, remote or not, rewrites the match flag
            n_answer_seen = (i_item.frame_id == r_asked_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_phase  <= 1'b0;
            r_current_id  <= ID_CONTROL;
            r_seq         <= '0;
            r_wait_count  <= '0;
            r_asked_id    <= '0;
            r_answer_seen <= 1'b0;
            r_req_valid   <= 1'b0;
            r_req_id      <= '0;
        end else if (i_item.accept) begin
            r_wait_phase  <= n_wait_phase;
            r_current_id  <= n_current_id;
            r_seq         <= n_seq;
            r_wait_count  <= n_wait_count;
            r_asked_id    <= n_asked_id;
            r_answer_seen <= n_answer_seen;
            r_req_valid   <= n_req_valid;
            r_req_id      <= n_req_id;
        end
    end

    assign o_req_valid = r_req_valid;
    assign o_req_id    = r_req_id;

endmodule

// ===== src/crpm_readback.sv =====
// crpm_readback: decodes non-remote data frames into nine readback words.
// Depends on crpm_pkg. Registers change only on an accepted frame.
module crpm_readback import crpm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    output t_regs o_regs
);

    t_regs r_regs, n_regs;

    always_comb begin
        n_regs = r_regs;
        if (i_item.kind == KIND_FRAME && !i_item.remote) begin
            unique case (i_item.frame_id)
                ID_CONTROL: n_regs[RB_CONTROL] = i_item.word0;
                ID_POWER:   n_regs[RB_POWER]   = i_item.word0;
                ID_VOLTAGE: n_regs[RB_VOLTAGE] = i_item.word0;
                ID_CURRENT: n_regs[RB_CURRENT] = i_item.word0;
                ID_STATUS: begin
                    n_regs[RB_STATUS] = i_item.word0;
                    n_regs[RB_ERROR]  = i_item.word1;
                end
                ID_MEASURE: begin
                    n_regs[RB_OPOWER]   = i_item.word0;
                    n_regs[RB_OVOLTAGE] = i_item.word1;
                    n_regs[RB_OCURRENT] = i_item.word2;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_item.accept) begin
            r_regs <= n_regs;
        end
    end

    assign o_regs = r_regs;

endmodule

// ===== src/can_register_poll_manager.sv =====
// can_register_poll_manager: top level, stream ports, config register and
// output handshake. Depends on crpm_pkg, crpm_sequencer, crpm_readback.
//
//  channel   dir  handshake               payload
//  s         in   i_s_tvalid/o_s_tready   tdata: id, remote, bytes; tuser: kind
//  m         out  o_m_tvalid/i_m_tready   tdata: req id, 9 words; tuser: req
//  cfg       in   i_cfg_we                i_cfg_wdata: timeout_limit
//
// One item per cycle while the m side takes results; the result appears on the m side in the cycle after acceptance.
// The state registers are loaded at the same edge as the result register,
// so the readback words in the result are the state itself.
// A new item is taken whenever the result register is empty or is being
// taken in the same cycle; a stalled m side stalls the s side.
// Reset is synchronous, active low; the result register comes up empty
// and timeout_limit comes up as 5.
module can_register_poll_manager import crpm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave side
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [SDataW-1:0]  i_s_tdata,   // frame_id[10:0], frame_remote[11],
                                            // data_byte0..5 [59:12], zero [63:60]
    input  logic               i_s_tuser,   // kind
    // master side
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [MDataW-1:0]  o_m_tdata,   // request_id[10:0], control_word,
                                            // power_setpoint, voltage_setpoint,
                                            // current_setpoint, status_word,
                                            // error_word, meas_power,
                                            // meas_voltage, meas_current,
                                            // zero [159:155]
    output logic               o_m_tuser,   // request_valid
    // configuration
    input  logic               i_cfg_we,
    input  logic [LimitW-1:0]  i_cfg_wdata  // timeout_limit
);

    logic              r_out_valid;
    logic [LimitW-1:0] r_timeout_limit;
    t_item             item;
    t_regs             regs;
    logic              req_valid;
    logic [IdW-1:0]    req_id;

    assign o_s_tready = !r_out_valid || i_m_tready;

    // unpack the input item; words are big-endian byte pairs
    assign item.accept   = i_s_tvalid && o_s_tready;
    assign item.kind     = i_s_tuser;
    assign item.frame_id = i_s_tdata[10:0];
    assign item.remote   = i_s_tdata[11];
    assign item.word0    = {i_s_tdata[19:12], i_s_tdata[27:20]};
    assign item.word1    = {i_s_tdata[35:28], i_s_tdata[43:36]};
    assign item.word2    = {i_s_tdata[51:44], i_s_tdata[59:52]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_timeout_limit <= LIMIT_RESET;
        end else begin
            if (item.accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_timeout_limit <= i_cfg_wdata;
            end
        end
    end

    crpm_sequencer u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (item),
        .i_timeout_limit (r_timeout_limit),
        .o_req_valid     (req_valid),
        .o_req_id        (req_id)
    );

    crpm_readback u_rb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .o_regs  (regs)
    );

    // pack result: request id lowest, then the nine words in slot order
    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[IdW-1:0] = req_id;
        for (int k = 0; k < NumRegs; k++) begin
            o_m_tdata[IdW + k*WordW +: WordW] = regs[k];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = req_valid;

endmodule

// ===== src/crpm_checker.sv =====
// crpm_checker: port-level assertions for can_register_poll_manager,
// bound to the top level below. Depends on crpm_pkg.
module crpm_checker import crpm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic              i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [MDataW-1:0] o_m_tdata,
    input logic              o_m_tuser
);

    logic [IdW-1:0] req_id;
    assign req_id = o_m_tdata[IdW-1:0];

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // every accepted item yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted item gave no result");

    // a frame never issues a request
    a_frame_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == KIND_FRAME |=> !o_m_tuser)
        else $error("frame issued a request");

    // requested ids come from the poll list; no request shows id zero
    a_req_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser && (req_id == ID_CONTROL || req_id == ID_POWER ||
            req_id == ID_VOLTAGE || req_id == ID_CURRENT || req_id == ID_STATUS ||
            req_id == ID_MEASURE)) || (!o_m_tuser && req_id == '0))
        else $error("bad request id");

    // result register empty in the first cycle out of reset
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind can_register_poll_manager crpm_checker u_crpm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
